FILE: rtl/ctc_pkg.sv
package ctc_pkg;

	localparam int MAX_KEYWORD_LEN = 6;
	localparam int CNT_W = $clog2(MAX_KEYWORD_LEN + 2);
	localparam int FIXED_TEXT_LEN = 6;
	localparam int FIXED_LEN_W = $clog2(FIXED_TEXT_LEN + 1);
	localparam int FIXED_COUNT = 44;
	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [5:0] CLASS_NUMBER = 6'd0;
	localparam logic [5:0] CLASS_IDENT = 6'd44;
	localparam logic [5:0] CLASS_INVALID = 6'd45;

	typedef logic [MAX_KEYWORD_LEN-1:0][7:0] prefix_t;

	typedef struct packed {
		prefix_t prefix;
		logic [CNT_W-1:0] count;
		logic all_digits;
		logic ident_ok;
		logic [15:0] row;
		logic [15:0] col;
	} lexeme_t;

	typedef struct packed {
		logic [8*FIXED_TEXT_LEN-1:0] text;
		logic [FIXED_LEN_W-1:0] len;
		logic [5:0] cls;
	} fixed_entry_t;

	localparam fixed_entry_t FIXED_TABLE [FIXED_COUNT] = '{
		'{48'("{"), 3'd1, 6'd1}, '{48'("}"), 3'd1, 6'd2},
		'{48'("("), 3'd1, 6'd3}, '{48'(")"), 3'd1, 6'd4},
		'{48'("int"), 3'd3, 6'd5}, '{48'("char"), 3'd4, 6'd5},
		'{48'("void"), 3'd4, 6'd6}, '{48'("return"), 3'd6, 6'd7},
		'{48'(";"), 3'd1, 6'd8}, '{48'("+"), 3'd1, 6'd9},
		'{48'("-"), 3'd1, 6'd10}, '{48'("*"), 3'd1, 6'd11},
		'{48'("/"), 3'd1, 6'd12}, '{48'("="), 3'd1, 6'd13},
		'{48'("+="), 3'd2, 6'd14}, '{48'("-="), 3'd2, 6'd15},
		'{48'("*="), 3'd2, 6'd16}, '{48'("/="), 3'd2, 6'd17},
		'{48'("=="), 3'd2, 6'd18}, '{48'("^"), 3'd1, 6'd19},
		'{48'("<"), 3'd1, 6'd20}, '{48'("<="), 3'd2, 6'd21},
		'{48'(">"), 3'd1, 6'd22}, '{48'(">="), 3'd2, 6'd23},
		'{48'("++"), 3'd2, 6'd24}, '{48'("--"), 3'd2, 6'd25},
		'{48'("&&"), 3'd2, 6'd26}, '{48'("||"), 3'd2, 6'd27},
		'{48'("!="), 3'd2, 6'd28}, '{48'("%"), 3'd1, 6'd29},
		'{48'("!"), 3'd1, 6'd30}, '{48'("~"), 3'd1, 6'd31},
		'{48'("&"), 3'd1, 6'd32}, '{48'("|"), 3'd1, 6'd33},
		'{48'("^="), 3'd2, 6'd34}, '{48'("%="), 3'd2, 6'd35},
		'{48'("|="), 3'd2, 6'd36}, '{48'("&="), 3'd2, 6'd37},
		'{48'("?"), 3'd1, 6'd38}, '{48'(":"), 3'd1, 6'd39},
		'{48'("\""), 3'd1, 6'd40}, '{48'("'"), 3'd1, 6'd41},
		'{48'("if"), 3'd2, 6'd42}, '{48'("else"), 3'd4, 6'd43}
	};

	function automatic logic [5:0] fixed_match(prefix_t prefix, logic [CNT_W-1:0] count);
		logic [8*FIXED_TEXT_LEN-1:0] text;
		logic [5:0] cls;
		logic hit;
		text = '0;
		cls = '0;
		hit = 1'b0;
		for (int j = 0; j < FIXED_TEXT_LEN; j++) begin
			if (CNT_W'(j) < count) begin
				text = {text[8*FIXED_TEXT_LEN-9:0], prefix[j]};
			end
		end
		for (int i = 0; i < FIXED_COUNT; i++) begin
			if (CNT_W'(FIXED_TABLE[i].len) == count && FIXED_TABLE[i].text == text) begin
				hit = 1'b1;
				cls = cls | FIXED_TABLE[i].cls;
			end
		end
		return hit ? cls : CLASS_INVALID;
	endfunction

endpackage

FILE: rtl/ctc_front.sv
module ctc_front
	import ctc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [7:0] char_code,
	input  logic is_last,
	input  logic [15:0] row,
	input  logic [15:0] col,
	output logic push,
	output lexeme_t push_data,
	input  logic q_ready
);

	prefix_t prefix_q;
	prefix_t prefix_next;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_next;
	logic all_digits_q;
	logic ident_ok_q;
	logic all_digits_next;
	logic ident_ok_next;
	logic is_digit;
	logic word_char;
	logic accept;

	assign in_ready = !is_last || q_ready;
	assign accept = in_valid && in_ready;
	assign push = accept && is_last;

	always_comb begin
		is_digit = (char_code >= 8'h30) && (char_code <= 8'h39);
		word_char = ((char_code >= 8'h41) && (char_code <= 8'h5a)) ||
			((char_code >= 8'h61) && (char_code <= 8'h7a)) || (char_code == 8'h5f);
		all_digits_next = all_digits_q && is_digit;
		if (count_q == '0) begin
			ident_ok_next = ident_ok_q && word_char;
		end else begin
			ident_ok_next = ident_ok_q && (word_char || is_digit);
		end
		for (int i = 0; i < MAX_KEYWORD_LEN; i++) begin
			prefix_next[i] = (count_q == CNT_W'(i)) ? char_code : prefix_q[i];
		end
		count_next = (count_q == CNT_W'(MAX_KEYWORD_LEN + 1)) ? count_q : count_q + 1'b1;
		push_data.prefix = prefix_next;
		push_data.count = count_next;
		push_data.all_digits = all_digits_next;
		push_data.ident_ok = ident_ok_next;
		push_data.row = row;
		push_data.col = col;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			all_digits_q <= 1'b1;
			ident_ok_q <= 1'b1;
		end else if (accept) begin
			if (is_last) begin
				count_q <= '0;
				all_digits_q <= 1'b1;
				ident_ok_q <= 1'b1;
			end else begin
				count_q <= count_next;
				all_digits_q <= all_digits_next;
				ident_ok_q <= ident_ok_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			prefix_q <= prefix_next;
		end
	end

endmodule

FILE: rtl/ctc_queue.sv
module ctc_queue
	import ctc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  lexeme_t push_data,
	output logic q_ready,
	output logic head_valid,
	output lexeme_t head_data,
	input  logic pop
);

	lexeme_t mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] fill_q;
	logic do_push;
	logic do_pop;

	assign q_ready = (fill_q != QCNT_W'(QDEPTH));
	assign head_valid = (fill_q != '0);
	assign head_data = mem_q[rd_ptr_q];
	assign do_push = push && q_ready;
	assign do_pop = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

FILE: rtl/ctc_back.sv
module ctc_back
	import ctc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic head_valid,
	input  lexeme_t head_data,
	output logic pop,
	output logic out_valid,
	input  logic out_ready,
	output logic [5:0] token_class,
	output logic [15:0] out_row,
	output logic [15:0] out_col
);

	logic out_valid_q;
	logic [5:0] class_q;
	logic [15:0] row_q;
	logic [15:0] col_q;
	logic [5:0] fixed_cls;
	logic [5:0] class_next;

	assign pop = head_valid && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign token_class = class_q;
	assign out_row = row_q;
	assign out_col = col_q;

	always_comb begin
		fixed_cls = fixed_match(head_data.prefix, head_data.count);
		priority if (head_data.all_digits) begin
			class_next = CLASS_NUMBER;
		end else if (head_data.count <= CNT_W'(MAX_KEYWORD_LEN) && fixed_cls != CLASS_INVALID) begin
			class_next = fixed_cls;
		end else if (head_data.ident_ok) begin
			class_next = CLASS_IDENT;
		end else begin
			class_next = CLASS_INVALID;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			class_q <= class_next;
			row_q <= head_data.row;
			col_q <= head_data.col;
		end
	end

endmodule

FILE: rtl/c_token_classifier_unit.sv
// Token classifier: takes one lexeme byte per beat (is_last marks the final byte) and returns one
// beat per lexeme with its class code (0 number, 1..43 fixed strings, 44 identifier, 45 invalid)
// and the row and column given with the last byte. A byte is taken every cycle unless a last byte
// meets a full queue; a lexeme is held first in the two-entry lexeme queue between the byte front
// end and the string matcher, and its class is then registered in the output register behind the
// matcher. A stalled output holds only last bytes once the queue fills; other bytes keep flowing.
module c_token_classifier_unit
	import ctc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [7:0] char_code,
	input  logic is_last,
	input  logic [15:0] row,
	input  logic [15:0] col,
	output logic out_valid,
	input  logic out_ready,
	output logic [5:0] token_class,
	output logic [15:0] out_row,
	output logic [15:0] out_col
);

	logic push;
	lexeme_t push_data;
	logic q_ready;
	logic head_valid;
	lexeme_t head_data;
	logic pop;

	ctc_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.char_code(char_code),
		.is_last(is_last),
		.row(row),
		.col(col),
		.push(push),
		.push_data(push_data),
		.q_ready(q_ready)
	);

	ctc_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data(push_data),
		.q_ready(q_ready),
		.head_valid(head_valid),
		.head_data(head_data),
		.pop(pop)
	);

	ctc_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head_valid(head_valid),
		.head_data(head_data),
		.pop(pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.token_class(token_class),
		.out_row(out_row),
		.out_col(out_col)
	);

endmodule
